/* src/max_tracking_stack_top_defines.svh */
// Assertion macros used by the top level of the max-tracking stack RTL.
`ifndef MAX_TRACKING_STACK_TOP_DEFINES_SVH
`define MAX_TRACKING_STACK_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define MTS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Checks that a consequent holds whenever an antecedent holds.
`define MTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define MTS_ASSERT(lbl, cond, msg)
`define MTS_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

/* src/mts_pkg.sv */
// Types and constants of the max-tracking stack.
package mts_pkg;

    // Number of entries the stack can hold.
    localparam int STACK_DEPTH = 1024;

    // Width of a stored value, of the depth field and of an entry address.
    localparam int DATA_WIDTH = 32;
    localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W     = $clog2(STACK_DEPTH);

    // Maximum reported while the stack is empty.
    localparam logic signed [DATA_WIDTH-1:0] MAX_EMPTY = '1;

    // Operation codes.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } t_err;

    // One input transaction.
    typedef struct packed {
        logic                         func;
        logic signed [DATA_WIDTH-1:0] push_value;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] popped_value;
        logic signed [DATA_WIDTH-1:0] top_value;
        logic signed [DATA_WIDTH-1:0] max_value;
        logic                         is_empty;
        logic [DEPTH_W-1:0]           depth_used;
        t_err                         error_code;
    } t_result;

    // One stack entry as held in memory.
    typedef struct packed {
        logic                         raised;
        logic signed [DATA_WIDTH-1:0] saved_max;
        logic signed [DATA_WIDTH-1:0] value;
    } t_entry;

endpackage

/* src/mts_ram.sv */
// Generic simple dual-port RAM with a registered read port.
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mts_engine.sv */
// Stack engine: top entry and maximum in registers, lower entries in RAM.
module mts_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  mts_pkg::t_item             i_item,
    output logic                       o_res_valid,
    input  logic                       i_res_stall,
    output mts_pkg::t_result           o_res,
    output logic                       o_mem_we,
    output logic [mts_pkg::ADDR_W-1:0] o_mem_waddr,
    output mts_pkg::t_entry            o_mem_wdata,
    output logic [mts_pkg::ADDR_W-1:0] o_mem_raddr,
    input  mts_pkg::t_entry            i_mem_rdata
);

    import mts_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    typedef enum logic [0:0] {
        S_RUN,
        S_FILL
    } t_state;

    t_state                       r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic signed [DATA_WIDTH-1:0] r_max, n_max;
    logic signed [DATA_WIDTH-1:0] r_top_val, n_top_val;
    logic signed [DATA_WIDTH-1:0] r_top_saved, n_top_saved;
    logic                         r_top_raised, n_top_raised;
    t_result                      r_res, n_res;
    logic                         r_res_vld, n_res_vld;

    logic                         accept;
    logic                         cnt_zero;
    logic                         cnt_one;
    logic                         cnt_full;
    logic                         raise;
    logic signed [DATA_WIDTH-1:0] restored_max;
    logic [CNT_W-1:0]             cnt_inc;
    logic [CNT_W-1:0]             cnt_dec;

    // Input is held off while the new top is fetched or the result slot is blocked.
    assign o_stall = (r_state == S_FILL) || (r_res_vld && i_res_stall);
    assign accept  = i_valid && !o_stall;

    // Decode of the current stack state.
    always_comb begin
        cnt_zero     = (r_count == '0);
        cnt_one      = (r_count == CNT_W'(1));
        cnt_full     = (r_count == DEPTH_CNT);
        cnt_inc      = r_count + CNT_W'(1);
        cnt_dec      = r_count - CNT_W'(1);
        raise        = cnt_zero || (i_item.push_value > r_max);
        restored_max = r_top_raised ? r_top_saved : r_max;
    end

    // The old top goes to memory on a push; the entry beneath it is read for a pop.
    assign o_mem_waddr = AW'(r_count - CNT_W'(1));
    assign o_mem_raddr = AW'(r_count - CNT_W'(2));
    assign o_mem_wdata = '{raised: r_top_raised, saved_max: r_top_saved, value: r_top_val};

    // Next-state logic for the stack and the result slot.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_max        = r_max;
        n_top_val    = r_top_val;
        n_top_saved  = r_top_saved;
        n_top_raised = r_top_raised;
        n_res        = r_res;
        n_res_vld    = r_res_vld && i_res_stall;
        o_mem_we     = 1'b0;

        if (r_state == S_FILL) begin
            // The entry beneath the popped one becomes the top.
            n_top_val       = i_mem_rdata.value;
            n_top_saved     = i_mem_rdata.saved_max;
            n_top_raised    = i_mem_rdata.raised;
            n_res.top_value = i_mem_rdata.value;
            n_res_vld       = 1'b1;
            n_state         = S_RUN;
        end else if (accept) begin
            n_res_vld = 1'b1;
            if (i_item.func == FUNC_PUSH) begin
                if (cnt_full) begin
                    n_res.popped_value = '0;
                    n_res.top_value    = r_top_val;
                    n_res.max_value    = r_max;
                    n_res.is_empty     = 1'b0;
                    n_res.depth_used   = DEPTH_W'(r_count);
                    n_res.error_code   = ERR_OVERFLOW;
                end else begin
                    o_mem_we     = !cnt_zero;
                    n_top_val    = i_item.push_value;
                    n_top_raised = raise;
                    n_top_saved  = raise ? (cnt_zero ? MAX_EMPTY : r_max) : '0;
                    n_max        = raise ? i_item.push_value : r_max;
                    n_count      = cnt_inc;
                    n_res.popped_value = '0;
                    n_res.top_value    = i_item.push_value;
                    n_res.max_value    = raise ? i_item.push_value : r_max;
                    n_res.is_empty     = 1'b0;
                    n_res.depth_used   = DEPTH_W'(cnt_inc);
                    n_res.error_code   = ERR_OK;
                end
            end else begin
                if (cnt_zero) begin
                    n_res.popped_value = '0;
                    n_res.top_value    = '0;
                    n_res.max_value    = MAX_EMPTY;
                    n_res.is_empty     = 1'b1;
                    n_res.depth_used   = '0;
                    n_res.error_code   = ERR_UNDERFLOW;
                end else if (cnt_one) begin
                    n_count = '0;
                    n_max   = restored_max;
                    n_res.popped_value = r_top_val;
                    n_res.top_value    = '0;
                    n_res.max_value    = MAX_EMPTY;
                    n_res.is_empty     = 1'b1;
                    n_res.depth_used   = '0;
                    n_res.error_code   = ERR_OK;
                end else begin
                    // New top arrives from memory next cycle.
                    n_count   = cnt_dec;
                    n_max     = restored_max;
                    n_state   = S_FILL;
                    n_res_vld = 1'b0;
                    n_res.popped_value = r_top_val;
                    n_res.top_value    = '0;
                    n_res.max_value    = restored_max;
                    n_res.is_empty     = 1'b0;
                    n_res.depth_used   = DEPTH_W'(cnt_dec);
                    n_res.error_code   = ERR_OK;
                end
            end
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_count   <= '0;
            r_max     <= MAX_EMPTY;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_max     <= n_max;
            r_res_vld <= n_res_vld;
        end
        r_top_val    <= n_top_val;
        r_top_saved  <= n_top_saved;
        r_top_raised <= n_top_raised;
        r_res        <= n_res;
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

/* src/max_tracking_stack_top.sv */
// Top level of the max-tracking stack: engine, entry RAM and output register.
//
// A LIFO of signed 32-bit values that reports its maximum with every result.
// Each transaction is a push or a pop and yields exactly one result. A pop that
// leaves one or more entries passes through the fill state before its result,
// as the entry beneath the top is read from the entry RAM, whose read port is
// registered; every other transaction finishes in the run state. The top entry
// and the running maximum live in registers, so a push needs only one RAM
// write. Results pass an output register, so a new transaction can be accepted
// while an earlier result waits to be taken. The entry RAM needs no clearing
// after reset; the block accepts transactions right away.
`include "max_tracking_stack_top_defines.svh"

module max_tracking_stack_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mts_pkg::t_item    i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mts_pkg::t_result  o_out_result
);

    import mts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic              res_valid;
    logic              res_stall;
    t_result           res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    t_entry            mem_wdata;
    t_entry            mem_rdata;
    logic              r_out_valid;
    t_result           r_out_res;

    // Stack control and top-of-stack registers.
    mts_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Entries below the top of the stack.
    mts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register takes a new result when empty or being drained.
    assign res_stall = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!res_stall) begin
            r_out_valid <= res_valid;
        end
        if (!res_stall && res_valid) begin
            r_out_res <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out_res;

    // An empty stack reports no top and the empty maximum.
    `MTS_ASSERT_IMPL(a_empty_fields, o_out_valid && o_out_result.is_empty,
        (o_out_result.top_value == '0) && (o_out_result.max_value == MAX_EMPTY),
        "empty result with nonzero top or max")

    // A failed transaction removes nothing.
    `MTS_ASSERT_IMPL(a_err_no_pop, o_out_valid && (o_out_result.error_code != ERR_OK),
        o_out_result.popped_value == '0, "error result carries a popped value")

    // Underflow happens only on an empty stack.
    `MTS_ASSERT_IMPL(a_underflow_empty,
        o_out_valid && (o_out_result.error_code == ERR_UNDERFLOW),
        o_out_result.is_empty && (o_out_result.depth_used == '0),
        "underflow on a nonempty stack")

endmodule

/* test/max_tracking_stack_top_tb.sv */
// Self-checking testbench for the max-tracking stack: directed and random push/pop traffic.
module max_tracking_stack_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT    = 100;

    logic    i_clk;
    logic    i_rst_n;
    logic    in_valid;
    logic    in_stall;
    t_item   in_item;
    logic    out_valid;
    logic    out_stall;
    t_result out_result;

    // Idle and stall rates of the current phase, in percent.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Predicted contents of the stack.
    logic signed [DATA_WIDTH-1:0] stack_vals   [STACK_DEPTH];
    logic signed [DATA_WIDTH-1:0] stack_saved  [STACK_DEPTH];
    logic                         stack_raised [STACK_DEPTH];
    int                           stack_count;
    logic signed [DATA_WIDTH-1:0] running_max;

    // Results predicted for accepted transactions, oldest first.
    t_result pending_stack_results[$];

    max_tracking_stack_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_result(out_result)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation to the predicted stack and returns the result it yields.
    function automatic t_result next_stack_result(input t_item op);
        t_result r;
        r = '0;
        r.error_code = ERR_OK;
        if (op.func == FUNC_PUSH) begin
            if (stack_count >= STACK_DEPTH) begin
                r.error_code = ERR_OVERFLOW;
            end else begin
                stack_vals[stack_count] = op.push_value;
                if (stack_count == 0 || op.push_value > running_max) begin
                    stack_raised[stack_count] = 1'b1;
                    stack_saved[stack_count]  = (stack_count == 0) ? MAX_EMPTY : running_max;
                    running_max               = op.push_value;
                end else begin
                    stack_raised[stack_count] = 1'b0;
                    stack_saved[stack_count]  = '0;
                end
                stack_count++;
            end
        end else begin
            if (stack_count == 0) begin
                r.error_code = ERR_UNDERFLOW;
            end else begin
                stack_count--;
                r.popped_value = stack_vals[stack_count];
                if (stack_raised[stack_count])
                    running_max = stack_saved[stack_count];
            end
        end
        if (stack_count > 0) begin
            r.top_value = stack_vals[stack_count-1];
            r.max_value = running_max;
            r.is_empty  = 1'b0;
        end else begin
            r.top_value = '0;
            r.max_value = MAX_EMPTY;
            r.is_empty  = 1'b1;
        end
        r.depth_used = stack_count[DEPTH_W-1:0];
        return r;
    endfunction

    // Picks a push value: random, small signed, extreme, or close to the running maximum.
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        logic signed [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = $urandom;
            end
            4, 5, 6: begin
                v = int'($urandom_range(0, 16)) - 8;
            end
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
                    1:       v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                    2:       v = '1;
                    default: v = '0;
                endcase
            end
            default: begin
                v = running_max + (int'($urandom_range(0, 2)) - 1);
            end
        endcase
        return v;
    endfunction

    // Prints one mismatch line (up to a limit) and counts it.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Sends one transaction, with random idle cycles ahead of it, and predicts its result.
    task automatic issue_operation(input t_item op);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item  = op;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        pending_stack_results.insert(pending_stack_results.size(), next_stack_result(op));
        @(negedge i_clk);
    endtask

    task automatic push_op(input logic signed [DATA_WIDTH-1:0] v);
        t_item op;
        op.func       = FUNC_PUSH;
        op.push_value = v;
        issue_operation(op);
    endtask

    // The value field of a pop is ignored, so it carries random bits.
    task automatic pop_op();
        t_item op;
        op.func       = FUNC_POP;
        op.push_value = $urandom;
        issue_operation(op);
    endtask

    task automatic run_random_ops(input int count, input int push_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < push_pct)
                push_op(pick_value());
            else
                pop_op();
        end
    endtask

    // Pops on the empty stack right after reset.
    task automatic test_underflow_after_reset();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pop_op();
        pop_op();
    endtask

    // Extreme values, including a push onto an empty stack and equal maxima.
    task automatic test_extreme_values();
        push_op({1'b1, {(DATA_WIDTH-1){1'b0}}});
        pop_op();
        push_op('1);
        push_op('1);
        pop_op();
        pop_op();
        push_op({1'b0, {(DATA_WIDTH-1){1'b1}}});
        push_op({1'b0, {(DATA_WIDTH-1){1'b1}}});
        push_op({1'b1, {(DATA_WIDTH-1){1'b0}}});
        pop_op();
        pop_op();
        pop_op();
    endtask

    // Duplicate and negative maxima must be restored by the raised flag alone.
    task automatic test_duplicate_negatives();
        push_op(-5);
        push_op(-3);
        push_op(-3);
        push_op(-7);
        push_op(-3);
        repeat (5) pop_op();
        pop_op();
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_ops(130, 55);
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct  = 63;
        recv_stall_pct = 0;
        run_random_ops(130, 50);
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        run_random_ops(130, 50);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random_ops(130, 50);
    endtask

    // Fills the stack, pushes past full, then mixes operations near the top.
    task automatic test_fill_and_overflow();
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        while (stack_count < STACK_DEPTH)
            push_op(pick_value());
        repeat (4) push_op(pick_value());
        pop_op();
        push_op(pick_value());
        push_op(pick_value());
        run_random_ops(20, 50);
    endtask

    // Receiver stall, changed at the falling edge.
    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_stack_results.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = pending_stack_results[0];
                pending_stack_results.delete(0);
                check_field("popped_value", out_result.popped_value, want.popped_value);
                check_field("top_value", out_result.top_value, want.top_value);
                check_field("max_value", out_result.max_value, want.max_value);
                check_field("is_empty", 32'(out_result.is_empty), 32'(want.is_empty));
                check_field("depth_used", 32'(out_result.depth_used), 32'(want.depth_used));
                check_field("error_code", 32'(out_result.error_code), 32'(want.error_code));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Reset, test sequence and final verdict.
    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        stack_count = 0;
        running_max = MAX_EMPTY;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_underflow_after_reset();
        test_extreme_values();
        test_duplicate_negatives();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        test_fill_and_overflow();

        // Let the remaining results drain.
        in_valid       = 1'b0;
        recv_stall_pct = 0;
        while (pending_stack_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
